// ===== hdl/tccc_pkg.sv =====
// ----------------------------------------------------------------------------
// tccc_pkg
// Types, source codes and helpers for the one- or two-pass colour combiner:
// request payloads, combiner source decode, operand fetch and the equation.
// ----------------------------------------------------------------------------
package tccc_pkg;

  // Configuration port
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_CYCLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIM      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENV       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LOD_K     = 3'd6;

  localparam int unsigned NUM_CH = 4;
  localparam int unsigned CH_W   = 9;   // combined value width
  localparam int unsigned OP_W   = 10;  // extended operand width

  // Register stages between the input and the output request
  localparam int NUM_STG = 4;

  localparam logic [CH_W-1:0] ONE_VAL = 9'h100;
  localparam logic [19:0]     ROUND   = 20'h80;

  // Request payloads
  typedef struct packed {
    logic [31:0] shade_rgba;
    logic [31:0] texel_zero_rgba;
    logic [31:0] texel_one_rgba;
    logic [7:0]  pixel_lod_fraction;
    logic        ends_packet;
  } in_pix_t;

  typedef struct packed {
    logic [31:0] out_rgba;
    logic        packet_done;
  } out_pix_t;

  // Combiner operand sources
  typedef enum logic [4:0] {
    SRC_COMB    = 5'd0,
    SRC_T0      = 5'd1,
    SRC_T1      = 5'd2,
    SRC_PRIM    = 5'd3,
    SRC_SHADE   = 5'd4,
    SRC_ENV     = 5'd5,
    SRC_ONE     = 5'd6,
    SRC_NOISE   = 5'd7,
    SRC_KEYC    = 5'd8,
    SRC_K4      = 5'd9,
    SRC_KEYS    = 5'd10,
    SRC_COMB_A  = 5'd11,
    SRC_T0_A    = 5'd12,
    SRC_T1_A    = 5'd13,
    SRC_PRIM_A  = 5'd14,
    SRC_SHADE_A = 5'd15,
    SRC_ENV_A   = 5'd16,
    SRC_LOD     = 5'd17,
    SRC_PLOD    = 5'd18,
    SRC_K5      = 5'd19,
    SRC_ZERO    = 5'd20
  } src_e;

  typedef struct packed {
    src_e a;
    src_e b;
    src_e c;
    src_e d;
  } sel_t;

  typedef struct packed {
    sel_t rgb;
    sel_t alpha;
  } cyc_sel_t;

  // Every value one channel may pick, already widened to 9 bits
  typedef struct packed {
    logic [CH_W-1:0] comb;
    logic [CH_W-1:0] comb_a;
    logic [CH_W-1:0] t0;
    logic [CH_W-1:0] t0_a;
    logic [CH_W-1:0] t1;
    logic [CH_W-1:0] t1_a;
    logic [CH_W-1:0] prim;
    logic [CH_W-1:0] prim_a;
    logic [CH_W-1:0] shade;
    logic [CH_W-1:0] shade_a;
    logic [CH_W-1:0] env;
    logic [CH_W-1:0] env_a;
    logic [CH_W-1:0] keyc;
    logic [CH_W-1:0] keys;
    logic [CH_W-1:0] lod;
    logic [CH_W-1:0] plod;
    logic [CH_W-1:0] k4;
    logic [CH_W-1:0] k5;
  } chan_src_t;

  // Operands of one channel after the subtract
  typedef struct packed {
    logic [OP_W-1:0] diff;
    logic [OP_W-1:0] c;
    logic [OP_W-1:0] d;
  } eq_t;

  // Source decode for each select field
  function automatic src_e dec_rgb_a(input logic [3:0] code);
    src_e s;
    if (code[3]) s = SRC_ZERO;
    else         s = src_e'({2'b00, code[2:0]});
    return s;
  endfunction

  function automatic src_e dec_rgb_b(input logic [3:0] code);
    src_e s;
    priority if (code[3])           s = SRC_ZERO;
    else if (code[2:0] == 3'd6)     s = SRC_KEYC;
    else if (code[2:0] == 3'd7)     s = SRC_K4;
    else                            s = src_e'({2'b00, code[2:0]});
    return s;
  endfunction

  function automatic src_e dec_rgb_c(input logic [4:0] code);
    src_e s;
    priority if (code[4])   s = SRC_ZERO;
    else if (code == 5'd6)  s = SRC_KEYS;
    else if (code > 5'd6)   s = src_e'(code + 5'd4);  // alphas, LOD, prim LOD, K5
    else                    s = src_e'(code);
    return s;
  endfunction

  function automatic src_e dec_rgb_d(input logic [2:0] code);
    src_e s;
    priority if (code == 3'd6) s = SRC_ONE;
    else if (code == 3'd7)     s = SRC_ZERO;
    else                       s = src_e'({2'b00, code});
    return s;
  endfunction

  function automatic src_e dec_alpha_abd(input logic [2:0] code);
    src_e s;
    priority if (code == 3'd6) s = SRC_ONE;
    else if (code == 3'd7)     s = SRC_ZERO;
    else                       s = src_e'({2'b00, code} + 5'd11);
    return s;
  endfunction

  function automatic src_e dec_alpha_c(input logic [2:0] code);
    src_e s;
    priority if (code == 3'd0) s = SRC_LOD;
    else if (code == 3'd6)     s = SRC_PLOD;
    else if (code == 3'd7)     s = SRC_ZERO;
    else                       s = src_e'({2'b00, code} + 5'd11);
    return s;
  endfunction

  // Gather the values one channel can see
  function automatic chan_src_t build_srcs(
    input logic [31:0]             shade,
    input logic [31:0]             t0,
    input logic [31:0]             t1,
    input logic [31:0]             prim,
    input logic [31:0]             env,
    input logic [23:0]             keyc,
    input logic [23:0]             keys,
    input logic [7:0]              lod,
    input logic [7:0]              plod,
    input logic [CH_W-1:0]         k4,
    input logic [CH_W-1:0]         k5,
    input logic [NUM_CH-1:0][CH_W-1:0] comb,
    input logic [1:0]              ch
  );
    chan_src_t   v;
    logic [4:0]  lsb;
    logic [31:0] keyc_w;
    logic [31:0] keys_w;
    lsb       = {ch, 3'b000};
    keyc_w    = {8'h00, keyc};
    keys_w    = {8'h00, keys};
    v.comb    = comb[ch];
    v.comb_a  = comb[3];
    v.t0      = {1'b0, t0[lsb +: 8]};
    v.t0_a    = {1'b0, t0[31:24]};
    v.t1      = {1'b0, t1[lsb +: 8]};
    v.t1_a    = {1'b0, t1[31:24]};
    v.prim    = {1'b0, prim[lsb +: 8]};
    v.prim_a  = {1'b0, prim[31:24]};
    v.shade   = {1'b0, shade[lsb +: 8]};
    v.shade_a = {1'b0, shade[31:24]};
    v.env     = {1'b0, env[lsb +: 8]};
    v.env_a   = {1'b0, env[31:24]};
    // key colours have no alpha byte, so the top byte reads as zero
    v.keyc    = {1'b0, keyc_w[lsb +: 8]};
    v.keys    = {1'b0, keys_w[lsb +: 8]};
    v.lod     = {1'b0, lod};
    v.plod    = {1'b0, plod};
    v.k4      = k4;
    v.k5      = k5;
    return v;
  endfunction

  function automatic logic [CH_W-1:0] fetch(input src_e s, input chan_src_t v);
    logic [CH_W-1:0] r;
    unique case (s)
      SRC_COMB:    r = v.comb;
      SRC_T0:      r = v.t0;
      SRC_T1:      r = v.t1;
      SRC_PRIM:    r = v.prim;
      SRC_SHADE:   r = v.shade;
      SRC_ENV:     r = v.env;
      SRC_ONE:     r = ONE_VAL;
      SRC_KEYC:    r = v.keyc;
      SRC_KEYS:    r = v.keys;
      SRC_K4:      r = v.k4;
      SRC_K5:      r = v.k5;
      SRC_COMB_A:  r = v.comb_a;
      SRC_T0_A:    r = v.t0_a;
      SRC_T1_A:    r = v.t1_a;
      SRC_PRIM_A:  r = v.prim_a;
      SRC_SHADE_A: r = v.shade_a;
      SRC_ENV_A:   r = v.env_a;
      SRC_LOD:     r = v.lod;
      SRC_PLOD:    r = v.plod;
      default:     r = '0;  // zero and noise
    endcase
    return r;
  endfunction

  // 0x180..0x1ff are negative, everything else positive
  function automatic logic [OP_W-1:0] sext9(input logic [CH_W-1:0] v);
    return {v[8] & v[7], v};
  endfunction

  // Select and subtract for one channel
  function automatic eq_t eval_ops(input chan_src_t v, input sel_t s);
    eq_t e;
    e.diff = sext9(fetch(s.a, v)) - sext9(fetch(s.b, v));
    e.c    = sext9(fetch(s.c, v));
    e.d    = sext9(fetch(s.d, v));
    return e;
  endfunction

  // ((A-B)*C + D*256 + 0x80) >> 8, kept to 9 bits
  function automatic logic [CH_W-1:0] mul_add(input eq_t e);
    logic [19:0] prod;
    logic [19:0] sum;
    prod = {{10{e.diff[OP_W-1]}}, e.diff} * {{10{e.c[OP_W-1]}}, e.c};
    sum  = prod + {{2{e.d[OP_W-1]}}, e.d, 8'h00} + ROUND;
    return sum[16:8];
  endfunction

  function automatic logic [7:0] clamp8(input logic [CH_W-1:0] v);
    logic [7:0] r;
    unique case (v[8:7])
      2'b10:   r = 8'hff;
      2'b11:   r = 8'h00;
      default: r = v[7:0];
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/two_cycle_color_combiner.sv =====
// ----------------------------------------------------------------------------
// two_cycle_color_combiner
// Per-pixel colour combiner with one or two combine cycles, four stages deep.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one pixel
//   request: shade, texel0, texel1, LOD fraction and end-of-packet marker.
//   Output channel (out_valid_o / out_ready_i / out_data_o) returns one
//   clamped RGBA colour per pixel, in order, with the marker copied.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i,
//   one register per cycle; the user must write only while no pixel is in flight.
//   The block itself does not enforce this.
// Path: an accepted request moves through stages 0, 1 and 2 and leaves from stage 3.
// Throughput: one pixel per cycle while out_ready_i is high. The four stages are
//   select+subtract and multiply-add for the first combine cycle, then the same for
//   the second; each stage holds one multiplier or one subtract per channel.
// Reset: all configuration registers clear to zero and the pipeline empties.
// Stall: each stage holds while the one after it is full and blocked, so a
//   stalled output still lets earlier empty stages fill; in_ready_o drops
//   only once all four stages are occupied.
// ----------------------------------------------------------------------------
module two_cycle_color_combiner
  import tccc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_pix_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_pix_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // Configuration registers
  logic [23:0] mode_hi_q;
  logic [31:0] mode_lo_q;
  logic        two_q;
  logic [31:0] prim_q;
  logic [31:0] env_q;
  logic [47:0] key_q;
  logic [25:0] lodk_q;

  // Pipeline
  logic [NUM_STG-1:0] vld_q;
  logic [NUM_STG-1:0] stg_rdy;

  eq_t     [NUM_CH-1:0]           s0_eq_d, s0_eq_q;
  in_pix_t                        s0_pix_q;
  logic    [NUM_CH-1:0][CH_W-1:0] s1_comb_d, s1_comb_q;
  in_pix_t                        s1_pix_q;
  eq_t     [NUM_CH-1:0]           s2_eq_d, s2_eq_q;
  logic                           s2_end_q;
  out_pix_t                       s3_out_d, s3_out_q;

  cyc_sel_t cyc0, cyc1;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_hi_q <= '0;
      mode_lo_q <= '0;
      two_q     <= 1'b0;
      prim_q    <= '0;
      env_q     <= '0;
      key_q     <= '0;
      lodk_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE_HIGH: mode_hi_q <= cfg_wdata_i[23:0];
        CFG_MODE_LOW:  mode_lo_q <= cfg_wdata_i[31:0];
        CFG_TWO_CYCLE: two_q     <= cfg_wdata_i[0];
        CFG_PRIM:      prim_q    <= cfg_wdata_i[31:0];
        CFG_ENV:       env_q     <= cfg_wdata_i[31:0];
        CFG_KEY:       key_q     <= cfg_wdata_i;
        CFG_LOD_K:     lodk_q    <= cfg_wdata_i[25:0];
        default: ;
      endcase
    end
  end

  // Decode the mode words into source selects
  always_comb begin
    cyc0.rgb.a   = dec_rgb_a(mode_hi_q[23:20]);
    cyc0.rgb.b   = dec_rgb_b(mode_lo_q[31:28]);
    cyc0.rgb.c   = dec_rgb_c(mode_hi_q[19:15]);
    cyc0.rgb.d   = dec_rgb_d(mode_lo_q[17:15]);
    cyc0.alpha.a = dec_alpha_abd(mode_hi_q[14:12]);
    cyc0.alpha.b = dec_alpha_abd(mode_lo_q[14:12]);
    cyc0.alpha.c = dec_alpha_c(mode_hi_q[11:9]);
    cyc0.alpha.d = dec_alpha_abd(mode_lo_q[11:9]);
    cyc1.rgb.a   = dec_rgb_a(mode_hi_q[8:5]);
    cyc1.rgb.b   = dec_rgb_b(mode_lo_q[27:24]);
    cyc1.rgb.c   = dec_rgb_c(mode_hi_q[4:0]);
    cyc1.rgb.d   = dec_rgb_d(mode_lo_q[8:6]);
    cyc1.alpha.a = dec_alpha_abd(mode_lo_q[23:21]);
    cyc1.alpha.b = dec_alpha_abd(mode_lo_q[5:3]);
    cyc1.alpha.c = dec_alpha_c(mode_lo_q[20:18]);
    cyc1.alpha.d = dec_alpha_abd(mode_lo_q[2:0]);
  end

  // Stage ready: a stage can load when empty or when it drains this cycle
  always_comb begin
    stg_rdy[NUM_STG-1] = !vld_q[NUM_STG-1] || out_ready_i;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      stg_rdy[k] = !vld_q[k] || stg_rdy[k+1];
    end
  end

  assign in_ready_o = stg_rdy[0];

  // First combine cycle: select and subtract, combined starts at zero
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      s0_eq_d[ch] = eval_ops(
        build_srcs(in_data_i.shade_rgba, in_data_i.texel_zero_rgba,
                   in_data_i.texel_one_rgba, prim_q, env_q, key_q[23:0],
                   key_q[47:24], in_data_i.pixel_lod_fraction, lodk_q[7:0],
                   lodk_q[16:8], lodk_q[25:17], '0, 2'(ch)),
        (ch == NUM_CH - 1) ? cyc0.alpha : cyc0.rgb);
    end
  end

  // First combine cycle: multiply and add
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      s1_comb_d[ch] = mul_add(s0_eq_q[ch]);
    end
  end

  // Second combine cycle: select and subtract, texels swapped when two_q is set
  always_comb begin
    logic [31:0]                   t0;
    logic [31:0]                   t1;
    logic [NUM_CH-1:0][CH_W-1:0]   comb;
    t0   = two_q ? s1_pix_q.texel_one_rgba  : s1_pix_q.texel_zero_rgba;
    t1   = two_q ? s1_pix_q.texel_zero_rgba : s1_pix_q.texel_one_rgba;
    comb = two_q ? s1_comb_q : '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      s2_eq_d[ch] = eval_ops(
        build_srcs(s1_pix_q.shade_rgba, t0, t1, prim_q, env_q, key_q[23:0],
                   key_q[47:24], s1_pix_q.pixel_lod_fraction, lodk_q[7:0],
                   lodk_q[16:8], lodk_q[25:17], comb, 2'(ch)),
        (ch == NUM_CH - 1) ? cyc1.alpha : cyc1.rgb);
    end
  end

  // Second combine cycle: multiply, add and clamp
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      s3_out_d.out_rgba[8*ch +: 8] = clamp8(mul_add(s2_eq_q[ch]));
    end
    s3_out_d.packet_done = s2_end_q;
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (stg_rdy[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NUM_STG; k++) begin
        if (stg_rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (stg_rdy[0] && in_valid_i) begin
      s0_eq_q  <= s0_eq_d;
      s0_pix_q <= in_data_i;
    end
    if (stg_rdy[1] && vld_q[0]) begin
      s1_comb_q <= s1_comb_d;
      s1_pix_q  <= s0_pix_q;
    end
    if (stg_rdy[2] && vld_q[1]) begin
      s2_eq_q  <= s2_eq_d;
      s2_end_q <= s1_pix_q.ends_packet;
    end
    if (stg_rdy[3] && vld_q[2]) begin
      s3_out_q <= s3_out_d;
    end
  end

  assign out_valid_o = vld_q[NUM_STG-1];
  assign out_data_o  = s3_out_q;

`ifndef SYNTH
  // A ready receiver keeps the whole pipeline flowing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked while output is ready");

  // Back-pressure reaches the input only when every stage is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (vld_q == '1))
    else $error("input blocked with an empty stage");

  // An accepted request lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted request lost at stage 0");

  // A blocked middle stage holds its combined value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[1] && !stg_rdy[2]) |=> (vld_q[1] && $stable(s1_comb_q)))
    else $error("stage 1 changed while stalled");
`endif

endmodule
